### sv/tesp_pkg.sv
// ----------------------------------------------------------------------------
// tesp_pkg
// Shared types and constants for the text escape stream parser: byte codes,
// parser modes, event kinds, register indexes and the colour stack size.
// ----------------------------------------------------------------------------
package tesp_pkg;

  // colour stack size and counter width (count runs 1..STACK_DEPTH)
  localparam int STACK_DEPTH = 16;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

  // configuration port
  localparam int CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_COLOUR = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT_TABS     = 8'd1;

  // register reset values
  localparam logic [31:0] RESET_COLOUR     = 32'h0000_00FF;
  localparam logic        RESET_COUNT_TABS = 1'b1;

  // content byte codes
  localparam logic [7:0] CH_TAB        = 8'h09;
  localparam logic [7:0] CH_CR         = 8'h0D;
  localparam logic [7:0] CH_ESC        = 8'h1B;
  localparam logic [7:0] CH_PRINT_LO   = 8'h20;
  localparam logic [7:0] START_LO      = 8'h40;
  localparam logic [7:0] START_HI      = 8'h5E;
  localparam logic [7:0] START_COLOUR  = 8'h43;
  localparam logic [7:0] END_LO        = 8'h60;
  localparam logic [7:0] END_HI        = 8'h7E;
  localparam logic [7:0] END_COLOUR    = 8'h63;
  localparam logic [7:0] COLOUR_PARAMS = 8'd4;
  localparam logic [7:0] TAB_MAX       = 8'd255;

  // parser modes
  localparam logic [1:0] MODE_NORMAL = 2'd0;
  localparam logic [1:0] MODE_CODE   = 2'd1;
  localparam logic [1:0] MODE_COUNT  = 2'd2;
  localparam logic [1:0] MODE_PARAMS = 2'd3;

  // event kinds
  localparam logic [2:0] KIND_TEXT   = 3'd0;
  localparam logic [2:0] KIND_TAB    = 3'd1;
  localparam logic [2:0] KIND_LINE   = 3'd2;
  localparam logic [2:0] KIND_COLOUR = 3'd3;
  localparam logic [2:0] KIND_NONE   = 3'd4;

  // control handed to the colour stack chain
  typedef struct packed {
    logic        push;      // shift every cell one place down, new top enters
    logic        pop;       // shift every cell one place up
    logic        load_top;  // overwrite the top cell only
    logic [31:0] top_data;  // value entering the top cell
  } stack_ctrl_t;

  // one result transaction
  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  text_byte;
    logic [31:0] item_colour;
    logic        new_item;
    logic [7:0]  tab_count;
    logic        stack_overflow;
    logic        end_of_content;
  } result_t;

endpackage

### sv/tesp_cell.sv
// ----------------------------------------------------------------------------
// tesp_cell
// One colour stack cell: takes the value of its upper neighbor on a push,
// of its lower neighbor on a pop, and holds otherwise.
// ----------------------------------------------------------------------------
module tesp_cell
  import tesp_pkg::*;
(
  input  logic        clk,
  input  logic        take_prev,
  input  logic        take_next,
  input  logic [31:0] prev_data,
  input  logic [31:0] next_data,
  output logic [31:0] data
);

  // entry register, push side wins
  always_ff @(posedge clk) begin
    if (take_prev) begin
      data <= prev_data;
    end else if (take_next) begin
      data <= next_data;
    end
  end

endmodule

### sv/tesp_stack.sv
// ----------------------------------------------------------------------------
// tesp_stack
// Colour stack built as a row of cells with the top in cell zero. Push and
// pop move every entry one cell per cycle; overflow rewrites the top cell.
// ----------------------------------------------------------------------------
module tesp_stack
  import tesp_pkg::*;
(
  input  logic        clk,
  input  stack_ctrl_t ctrl,
  output logic [31:0] top,
  output logic [31:0] second
);

  logic [31:0] cell_q [STACK_DEPTH];

  // chain of cells, each wired to both neighbors
  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    logic        take_prev;
    logic [31:0] prev_data;
    logic [31:0] next_data;

    if (i == 0) begin : g_top
      assign take_prev = ctrl.push | ctrl.load_top;
      assign prev_data = ctrl.top_data;
    end else begin : g_inner
      assign take_prev = ctrl.push;
      assign prev_data = cell_q[i-1];
    end

    if (i == STACK_DEPTH - 1) begin : g_bottom
      assign next_data = cell_q[i];
    end else begin : g_link
      assign next_data = cell_q[i+1];
    end

    tesp_cell u_cell (
      .clk       (clk),
      .take_prev (take_prev),
      .take_next (ctrl.pop),
      .prev_data (prev_data),
      .next_data (next_data),
      .data      (cell_q[i])
    );
  end

  assign top    = cell_q[0];
  assign second = cell_q[1];

endmodule

### sv/text_escape_stream_parser.sv
// ----------------------------------------------------------------------------
// text_escape_stream_parser
// Splits a stream of text content bytes into text, tab, line break and
// colour change events, following escape sequences and a colour stack.
// ----------------------------------------------------------------------------
// The parser takes one content byte per clock while in_stall is low and
// returns exactly one result transaction per byte. All parser state and the
// colour stack move on the edge that accepts the byte: the stack is a row
// of cells that shift one place on a push or pop, so the byte rate is set by
// the escape decode plus the stack move, one byte per cycle. An output
// register with a one-entry skid stage lets input continue while a result
// waits. The colour stack needs no clearing pass after reset; only the top
// cell is reloaded. Writing default_colour restarts the parser.
module text_escape_stream_parser
  import tesp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  // content byte input
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           data_byte,
  input  logic                 last,
  // event output
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [2:0]           kind,
  output logic [7:0]           text_byte,
  output logic [31:0]          item_colour,
  output logic                 new_item,
  output logic [7:0]           tab_count,
  output logic                 stack_overflow,
  output logic                 end_of_content,
  // configuration write
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  // configuration registers
  logic [31:0] default_colour;
  logic        count_tabs;

  // parser state
  logic [1:0]       parse_mode, parse_mode_next;
  logic             capture_colour, capture_colour_next;
  logic [7:0]       params_left, params_left_next;
  logic [23:0]      colour_bytes, colour_bytes_next;
  logic             item_has_text, item_has_text_next;
  logic [7:0]       tabs_before_item, tabs_before_item_next;
  logic [CNT_W-1:0] stack_count, stack_count_next;

  // output staging
  result_t out_q, skid_q, res;
  logic    skid_valid;

  logic        in_acc, cfg_acc, cfg_restart, restart;
  logic        push, pop, load_top;
  logic [31:0] new_colour, stack_top, stack_second;
  stack_ctrl_t sctrl;

  assign cfg_ready   = 1'b1;
  assign cfg_acc     = cfg_valid & cfg_ready;
  assign cfg_restart = cfg_acc && (cfg_index == CFG_DEFAULT_COLOUR);
  assign in_stall    = skid_valid;
  assign in_acc      = in_valid & ~in_stall;
  assign restart     = rst | cfg_restart | (in_acc & last);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      default_colour <= RESET_COLOUR;
      count_tabs     <= RESET_COUNT_TABS;
    end else if (cfg_acc) begin
      if (cfg_index == CFG_DEFAULT_COLOUR) begin
        default_colour <= cfg_data;
      end else if (cfg_index == CFG_COUNT_TABS) begin
        count_tabs <= cfg_data[0];
      end
    end
  end

  // escape decode and item bookkeeping for one byte
  always_comb begin
    logic normal;
    normal                = 1'b0;
    parse_mode_next       = parse_mode;
    capture_colour_next   = capture_colour;
    params_left_next      = params_left;
    colour_bytes_next     = colour_bytes;
    item_has_text_next    = item_has_text;
    tabs_before_item_next = tabs_before_item;
    stack_count_next      = stack_count;
    push                  = 1'b0;
    pop                   = 1'b0;
    load_top              = 1'b0;
    new_colour            = {colour_bytes, ~data_byte};
    res                   = '0;
    res.kind              = KIND_NONE;

    unique case (parse_mode)
      MODE_CODE: begin
        parse_mode_next = MODE_NORMAL;
        if (data_byte >= START_LO && data_byte <= START_HI) begin
          parse_mode_next     = MODE_COUNT;
          capture_colour_next = (data_byte == START_COLOUR);
        end else if (data_byte >= END_LO && data_byte <= END_HI) begin
          // colour end code pops, never below the bottom entry
          if (data_byte == END_COLOUR && stack_count > CNT_W'(1)) begin
            pop              = 1'b1;
            stack_count_next = stack_count - CNT_W'(1);
            res.new_item     = item_has_text;
            if (item_has_text) begin
              item_has_text_next    = 1'b0;
              tabs_before_item_next = '0;
            end
            res.kind = KIND_COLOUR;
          end
        end else begin
          normal = 1'b1;
        end
      end
      MODE_COUNT: begin
        params_left_next  = data_byte;
        colour_bytes_next = '0;
        if (data_byte != COLOUR_PARAMS) begin
          capture_colour_next = 1'b0;
        end
        parse_mode_next = (data_byte == 8'd0) ? MODE_NORMAL : MODE_PARAMS;
      end
      MODE_PARAMS: begin
        if (capture_colour) begin
          if (params_left > 8'd1) begin
            colour_bytes_next = {colour_bytes[15:0], data_byte};
          end else begin
            // fourth parameter completes the colour
            res.new_item = item_has_text;
            if (item_has_text) begin
              item_has_text_next    = 1'b0;
              tabs_before_item_next = '0;
            end
            if (stack_count >= CNT_W'(STACK_DEPTH)) begin
              load_top           = 1'b1;
              res.stack_overflow = 1'b1;
            end else begin
              push             = 1'b1;
              stack_count_next = stack_count + CNT_W'(1);
            end
            res.kind = KIND_COLOUR;
          end
        end
        params_left_next = params_left - 8'd1;
        if (params_left_next == 8'd0) begin
          parse_mode_next     = MODE_NORMAL;
          capture_colour_next = 1'b0;
        end
      end
      default: begin
        normal = 1'b1;
      end
    endcase

    // ordinary byte handling
    if (normal) begin
      priority if (data_byte == CH_TAB) begin
        res.new_item = item_has_text_next;
        if (item_has_text_next) begin
          item_has_text_next    = 1'b0;
          tabs_before_item_next = '0;
        end
        if (count_tabs && tabs_before_item_next != TAB_MAX) begin
          tabs_before_item_next = tabs_before_item_next + 8'd1;
        end
        res.kind = KIND_TAB;
      end else if (data_byte == CH_CR) begin
        item_has_text_next    = 1'b0;
        tabs_before_item_next = '0;
        res.new_item          = 1'b1;
        res.kind              = KIND_LINE;
      end else if (data_byte == CH_ESC) begin
        parse_mode_next = MODE_CODE;
      end else if (data_byte >= CH_PRINT_LO) begin
        item_has_text_next = 1'b1;
        res.text_byte      = data_byte;
        res.kind           = KIND_TEXT;
      end else begin
        // other control bytes are dropped
        res.kind = KIND_NONE;
      end
    end

    res.item_colour    = (push | load_top) ? new_colour :
                         pop               ? stack_second : stack_top;
    res.tab_count      = tabs_before_item_next;
    res.end_of_content = last;
  end

  // parser state registers
  always_ff @(posedge clk) begin
    if (restart) begin
      parse_mode       <= MODE_NORMAL;
      capture_colour   <= 1'b0;
      params_left      <= '0;
      colour_bytes     <= '0;
      item_has_text    <= 1'b0;
      tabs_before_item <= '0;
      stack_count      <= CNT_W'(1);
    end else if (in_acc) begin
      parse_mode       <= parse_mode_next;
      capture_colour   <= capture_colour_next;
      params_left      <= params_left_next;
      colour_bytes     <= colour_bytes_next;
      item_has_text    <= item_has_text_next;
      tabs_before_item <= tabs_before_item_next;
      stack_count      <= stack_count_next;
    end
  end

  // stack control, restart reloads the top cell with the base colour
  always_comb begin
    sctrl          = '0;
    sctrl.push     = in_acc & push & ~restart;
    sctrl.pop      = in_acc & pop & ~restart;
    sctrl.load_top = restart | (in_acc & load_top);
    if (rst) begin
      sctrl.top_data = RESET_COLOUR;
    end else if (cfg_restart) begin
      sctrl.top_data = cfg_data;
    end else if (in_acc & last) begin
      sctrl.top_data = default_colour;
    end else begin
      sctrl.top_data = new_colour;
    end
  end

  tesp_stack u_stack (
    .clk    (clk),
    .ctrl   (sctrl),
    .top    (stack_top),
    .second (stack_second)
  );

  // output register with skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= in_acc;
      end
    end else if (in_acc) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || !out_stall) begin
      out_q <= skid_valid ? skid_q : res;
    end else if (in_acc) begin
      skid_q <= res;
    end
  end

  assign kind           = out_q.kind;
  assign text_byte      = out_q.text_byte;
  assign item_colour    = out_q.item_colour;
  assign new_item       = out_q.new_item;
  assign tab_count      = out_q.tab_count;
  assign stack_overflow = out_q.stack_overflow;
  assign end_of_content = out_q.end_of_content;

  // stack count stays within the cell row
  assert property (@(posedge clk) disable iff (rst)
    stack_count != '0 && stack_count <= CNT_W'(STACK_DEPTH))
    else $error("colour stack count out of range");

  // a held skid entry implies the output register is full
  assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry without output entry");

  // a pop that is not overridden by a restart lowers the count by one
  assert property (@(posedge clk) disable iff (rst)
    (sctrl.pop && !restart) |=> stack_count == $past(stack_count) - CNT_W'(1))
    else $error("colour pop did not lower the stack count");

  // an overflow result never comes with a growing stack
  assert property (@(posedge clk) disable iff (rst)
    (in_acc && res.stack_overflow && !restart) |=> stack_count == CNT_W'(STACK_DEPTH))
    else $error("overflow reported with stack not full");

endmodule
